>>> design/dvk_pkg.sv
// Shared types and constants of the delta varint key encoder.
package dvk_pkg;

   localparam int KEY_W      = 64;
   localparam int WORD_W     = 16;
   // Holds a highest group index up to 15, enough for group widths of four bits or more (up to sixteen groups).
   localparam int LAST_IDX_W = 4;

   // One classified key waiting for the word emitter.
   typedef struct packed {
      logic [KEY_W-1:0]      diff;
      logic [LAST_IDX_W-1:0] last_idx;
      logic                  new_prefix;
   } diff_entry_type;

   // One finished code word waiting for the receiver.
   typedef struct packed {
      logic [WORD_W-1:0] code_word;
      logic              word_last;
      logic              new_prefix;
   } word_entry_type;

endpackage

>>> design/delta_varint_key_encoder.sv
// Top level of the delta varint key encoder.
//
// Keys enter through a queue-like port: an item is taken at a clock edge where
// push is high and full is low. Each key is reduced to its difference from the
// previous key (modulo 2^64; zero after reset and after a key with block_last
// set), and that difference leaves as one to ceil(64/GROUP_BITS) code words.
// Results are read like a queue: while empty is low the oldest word sits on
// the rsp_ ports, and it is taken at an edge where pop is high.
// A key is classified in the cycle it is accepted and placed in a two-entry
// queue; the word emitter then sends one word per cycle while the result queue
// has room, one word for each group of the key. A word passes from the key
// queue through the emitter into the result queue, whose oldest entry is on
// the rsp_ ports.
// Throughput is set by the emitter: one word per cycle while the result queue
// has room, which is one key per cycle for small differences.
// When the receiver stalls, the two-entry result queue fills, the emitter
// holds, the key queue fills, and full rises. Synchronous reset empties both
// queues and clears the previous key.
module delta_varint_key_encoder #(
   parameter int GROUP_BITS      = 15,
   parameter int PREFIX_LOW_BITS = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic [dvk_pkg::KEY_W-1:0] req_key_value,
   input  logic                      req_block_last,
   output logic                      empty,
   input  logic                      pop,
   output logic [dvk_pkg::WORD_W-1:0] rsp_code_word,
   output logic                      rsp_word_last,
   output logic                      rsp_new_prefix
);
   import dvk_pkg::*;

   diff_entry_type front_entry;
   diff_entry_type back_entry;
   logic           accept;
   logic           entry_empty;
   logic           entry_pop;
   word_entry_type back_word;
   word_entry_type out_word;
   logic           word_push;
   logic           word_full;

   assign accept = push && !full;

   // Classification of incoming keys.
   dvk_front #(
      .GROUP_BITS      (GROUP_BITS),
      .PREFIX_LOW_BITS (PREFIX_LOW_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .key_value  (req_key_value),
      .block_last (req_block_last),
      .entry      (front_entry)
   );

   // Queue between classification and word emission.
   dvk_fifo #(
      .WIDTH ($bits(diff_entry_type))
   ) u_entry_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (front_entry),
      .full    (full),
      .pop     (entry_pop),
      .rd_data (back_entry),
      .empty   (entry_empty)
   );

   // Word emission.
   dvk_back #(
      .GROUP_BITS (GROUP_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .entry       (back_entry),
      .entry_empty (entry_empty),
      .entry_pop   (entry_pop),
      .word        (back_word),
      .word_push   (word_push),
      .word_full   (word_full)
   );

   // Result queue toward the receiver.
   dvk_fifo #(
      .WIDTH ($bits(word_entry_type))
   ) u_word_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (word_push),
      .wr_data (back_word),
      .full    (word_full),
      .pop     (pop),
      .rd_data (out_word),
      .empty   (empty)
   );

   assign rsp_code_word  = out_word.code_word;
   assign rsp_word_last  = out_word.word_last;
   assign rsp_new_prefix = out_word.new_prefix;

endmodule

>>> design/dvk_fifo.sv
// Two-entry queue used between the encoder stages and at the result side.
module dvk_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             do_push;
   logic             do_pop;

   // Handshake qualification.
   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> design/dvk_front.sv
// Front stage: takes keys, forms the wrapped difference, counts its groups.
module dvk_front #(
   parameter int GROUP_BITS      = 15,
   parameter int PREFIX_LOW_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [dvk_pkg::KEY_W-1:0] key_value,
   input  logic                  block_last,
   output dvk_pkg::diff_entry_type entry
);
   import dvk_pkg::*;

   localparam int MAX_GROUPS = (KEY_W + GROUP_BITS - 1) / GROUP_BITS;
   localparam logic [KEY_W-1:0] LOW_ONES =
      (PREFIX_LOW_BITS >= KEY_W) ? {KEY_W{1'b1}} : ((KEY_W'(1) << PREFIX_LOW_BITS) - KEY_W'(1));
   localparam logic [KEY_W-1:0] PREFIX_MASK = ~LOW_ONES;

   logic [KEY_W-1:0]      previous_key_ff;
   logic [KEY_W-1:0]      previous_key_in;
   logic [KEY_W-1:0]      diff;
   logic [LAST_IDX_W-1:0] last_idx;

   // Difference modulo 2^64 and the index of its highest nonzero group.
   always_comb begin
      diff     = key_value - previous_key_ff;
      last_idx = '0;
      for (int g = 1; g < MAX_GROUPS; g++) begin
         if (GROUP_BITS'(diff >> (g * GROUP_BITS)) != '0) begin
            last_idx = LAST_IDX_W'(g);
         end
      end
   end

   assign entry.diff       = diff;
   assign entry.last_idx   = last_idx;
   assign entry.new_prefix = |((key_value ^ previous_key_ff) & PREFIX_MASK);

   // The previous key returns to zero after the last key of a block.
   assign previous_key_in = block_last ? '0 : key_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_key_ff <= '0;
      end else if (accept) begin
         previous_key_ff <= previous_key_in;
      end
   end

endmodule

>>> design/dvk_back.sv
// Back stage: sends the groups of one difference, most significant first.
module dvk_back #(
   parameter int GROUP_BITS = 15
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dvk_pkg::diff_entry_type entry,
   input  logic                    entry_empty,
   output logic                    entry_pop,
   output dvk_pkg::word_entry_type word,
   output logic                    word_push,
   input  logic                    word_full
);
   import dvk_pkg::*;

   localparam int MAX_GROUPS = (KEY_W + GROUP_BITS - 1) / GROUP_BITS;
   localparam int IDX_W      = $clog2(MAX_GROUPS);
   localparam int WIDE_W     = (GROUP_BITS + 1 > WORD_W) ? GROUP_BITS + 1 : WORD_W;

   logic [GROUP_BITS-1:0] groups [MAX_GROUPS];
   logic [IDX_W-1:0]      idx_ff;
   logic [IDX_W-1:0]      idx_in;
   logic                  started_ff;
   logic                  started_in;
   logic [IDX_W-1:0]      cur_idx;
   logic                  final_word;
   logic [WIDE_W-1:0]     wide_word;

   // Cut the difference into groups.
   always_comb begin
      for (int g = 0; g < MAX_GROUPS; g++) begin
         groups[g] = GROUP_BITS'(entry.diff >> (g * GROUP_BITS));
      end
   end

   // The first word of an item starts at its highest group.
   assign cur_idx    = started_ff ? idx_ff : entry.last_idx[IDX_W-1:0];
   assign final_word = (cur_idx == '0);
   assign wide_word  = WIDE_W'({final_word, groups[cur_idx]});

   assign word.code_word  = wide_word[WORD_W-1:0];
   assign word.word_last  = final_word;
   assign word.new_prefix = entry.new_prefix;
   assign word_push       = !entry_empty && !word_full;
   assign entry_pop       = word_push && final_word;

   // Step down one group per word sent.
   always_comb begin
      idx_in     = idx_ff;
      started_in = started_ff;
      if (word_push) begin
         if (final_word) begin
            started_in = 1'b0;
         end else begin
            idx_in     = cur_idx - IDX_W'(1);
            started_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         started_ff <= 1'b0;
      end else begin
         idx_ff     <= idx_in;
         started_ff <= started_in;
      end
   end

endmodule

>>> test/tb_delta_varint_key_encoder.sv
// Testbench for the delta varint key encoder: directed and random key streams checked word by word.
`default_nettype none

module tb_delta_varint_key_encoder;
   timeunit 1ns;
   timeprecision 1ps;

   import dvk_pkg::*;

   localparam int GROUP_BITS      = 15;
   localparam int PREFIX_LOW_BITS = 24;
   localparam int MAX_GROUPS      = (KEY_W + GROUP_BITS - 1) / GROUP_BITS;
   localparam int STALL_LIMIT     = 2000;
   localparam int HOLD_CYCLES     = 100;
   localparam int DRAIN_CYCLES    = 8;

   logic               clock;
   logic               reset;
   logic               push;
   logic               full;
   logic [KEY_W-1:0]   req_key_value;
   logic               req_block_last;
   logic               empty;
   logic               pop;
   logic [WORD_W-1:0]  rsp_code_word;
   logic               rsp_word_last;
   logic               rsp_new_prefix;

   // Predictor state and the words it still expects, oldest first.
   logic [KEY_W-1:0]   prev_key_model;
   word_entry_type     expected_words[$];
   int                 mismatch_count;

   // Idling controls for the sender and the receiver, and the watchdog count.
   int                 send_idle_pct;
   int                 rsp_stall_pct;
   int                 hold_requests;
   int                 hold_served;
   int                 hold_left;
   int                 quiet_cycles;

   delta_varint_key_encoder #(
      .GROUP_BITS      (GROUP_BITS),
      .PREFIX_LOW_BITS (PREFIX_LOW_BITS)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_key_value  (req_key_value),
      .req_block_last (req_block_last),
      .empty          (empty),
      .pop            (pop),
      .rsp_code_word  (rsp_code_word),
      .rsp_word_last  (rsp_word_last),
      .rsp_new_prefix (rsp_new_prefix)
   );

   // Free-running clock with a 4 ns period.
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Works out the code words of one key and queues them, most significant group first.
   function automatic void predict_key_words(input logic [KEY_W-1:0] key, input logic ends_block);
      logic [KEY_W-1:0] diff;
      logic [KEY_W-1:0] group_mask;
      logic [KEY_W-1:0] prefix_mask;
      logic [KEY_W-1:0] groups [0:MAX_GROUPS-1];
      logic [KEY_W-1:0] w;
      logic             prefix_changed;
      word_entry_type   entry;
      int               n;
      diff = key - prev_key_model;
      group_mask = (64'd1 << GROUP_BITS) - 64'd1;
      prefix_mask = (PREFIX_LOW_BITS >= 64) ? 64'd0 : ~((64'd1 << PREFIX_LOW_BITS) - 64'd1);
      prefix_changed = ((key & prefix_mask) != (prev_key_model & prefix_mask));
      // The lowest group always goes out; higher groups only while bits remain.
      n = 0;
      groups[n] = diff & group_mask;
      n++;
      diff = diff >> GROUP_BITS;
      while (diff != 64'd0 && n < MAX_GROUPS) begin
         groups[n] = diff & group_mask;
         n++;
         diff = diff >> GROUP_BITS;
      end
      for (int k = n - 1; k >= 0; k--) begin
         w = groups[k];
         if (k == 0) begin
            w = w | (64'd1 << GROUP_BITS);
         end
         entry.code_word  = w[WORD_W-1:0];
         entry.word_last  = (k == 0);
         entry.new_prefix = prefix_changed;
         expected_words.push_back(entry);
      end
      prev_key_model = ends_block ? '0 : key;
   endfunction

   function automatic logic [KEY_W-1:0] rand_key();
      return {$urandom(), $urandom()};
   endfunction

   // Random key step, weighted toward the small differences of sorted keys.
   function automatic logic [KEY_W-1:0] rand_step();
      int width;
      int pick;
      pick = $urandom_range(99);
      if (pick < 50) begin
         width = $urandom_range(15, 0);
      end else if (pick < 80) begin
         width = $urandom_range(30, 16);
      end else begin
         width = $urandom_range(64, 31);
      end
      return (width == 0) ? '0 : (rand_key() >> (64 - width));
   endfunction

   // Offers one item until it is taken, predicts its words, then maybe idles.
   task automatic send_key(input logic [KEY_W-1:0] key, input logic ends_block);
      push           <= 1'b1;
      req_key_value  <= key;
      req_block_last <= ends_block;
      do @(posedge clock); while (full);
      predict_key_words(key, ends_block);
      if ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   task automatic set_idling(input int send_pct, input int rsp_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = rsp_pct;
   endtask

   // Zero and repeated keys, group boundaries, prefix edges, wrap-around and block ends.
   task automatic test_directed_edges();
      send_key(64'd0, 1'b0);
      send_key(64'd0, 1'b0);
      send_key(64'd1, 1'b0);
      send_key(64'h8000, 1'b0);
      send_key(64'h1_0000, 1'b0);
      send_key(64'h1_0000 + (64'd1 << 30), 1'b0);
      send_key(64'hFF_FFFF, 1'b0);
      send_key(64'h100_0000, 1'b0);
      send_key(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_key(64'd0, 1'b0);
      send_key(64'h5555_5555_5555_5555, 1'b1);
      send_key(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      send_key(64'h1000_0000_0000_0000, 1'b0);
      send_key(64'd1 << 45, 1'b1);
      send_key(64'd1 << 60, 1'b0);
      send_key(64'h8000_0000_0000_0000, 1'b1);
      send_key(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      send_key(64'd0, 1'b1);
   endtask

   // Sorted blocks of random length; a few keys jump anywhere to break the order.
   task automatic test_random_blocks(input int n_keys);
      logic [KEY_W-1:0] cur;
      int               sent;
      int               blk_len;
      sent = 0;
      while (sent < n_keys) begin
         blk_len = $urandom_range(12, 1);
         if (blk_len > n_keys - sent) begin
            blk_len = n_keys - sent;
         end
         cur = '0;
         for (int i = 0; i < blk_len; i++) begin
            if ($urandom_range(99) < 8) begin
               cur = rand_key();
            end else begin
               cur = cur + rand_step();
            end
            send_key(cur, i == blk_len - 1);
            sent++;
         end
      end
   endtask

   // The receiver holds off for a long stretch while keys keep coming, so full must rise.
   task automatic test_full_backpressure();
      set_idling(0, 0);
      hold_requests = hold_requests + 1;
      test_random_blocks(24);
   endtask

   // Receiver: checks every taken word against the oldest expectation and decides pop.
   always @(posedge clock) begin
      word_entry_type want;
      if (reset) begin
         pop         <= 1'b0;
         hold_served <= 0;
         hold_left   <= 0;
      end else begin
         if (pop && !empty) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word: actual code_word=%h word_last=%b new_prefix=%b",
                        $time, rsp_code_word, rsp_word_last, rsp_new_prefix);
               mismatch_count = mismatch_count + 1;
            end else begin
               want = expected_words.pop_front();
               if (rsp_code_word !== want.code_word) begin
                  $display("%0t: code_word mismatch: expected %h actual %h",
                           $time, want.code_word, rsp_code_word);
                  mismatch_count = mismatch_count + 1;
               end
               if (rsp_word_last !== want.word_last) begin
                  $display("%0t: word_last mismatch: expected %b actual %b",
                           $time, want.word_last, rsp_word_last);
                  mismatch_count = mismatch_count + 1;
               end
               if (rsp_new_prefix !== want.new_prefix) begin
                  $display("%0t: new_prefix mismatch: expected %b actual %b",
                           $time, want.new_prefix, rsp_new_prefix);
                  mismatch_count = mismatch_count + 1;
               end
            end
         end
         // A pending long hold wins over the random stall choice.
         if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            pop         <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            pop       <= 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Watchdog: ends the run after too many cycles in which no item or word moves.
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL delta_varint_key_encoder");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Test sequence.
   initial begin
      reset          = 1'b1;
      push           = 1'b0;
      req_key_value  = '0;
      req_block_last = 1'b0;
      prev_key_model = '0;
      send_idle_pct  = 0;
      rsp_stall_pct  = 0;
      hold_requests  = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idling(0, 0);
      test_directed_edges();
      set_idling(0, 0);
      test_random_blocks(50);
      set_idling(83, 0);
      test_random_blocks(50);
      set_idling(0, 83);
      test_random_blocks(50);
      set_idling(14, 14);
      test_random_blocks(50);
      test_full_backpressure();
      push <= 1'b0;

      // Drain the remaining words, then let the block idle before the verdict.
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS delta_varint_key_encoder");
      end else begin
         $display("FAIL delta_varint_key_encoder");
      end
      $finish;
   end

endmodule

`default_nettype wire
